### hw/rtl/lfim_pkg.sv
// Shared constants, types and fixed-point helpers for the line interaction matrix block.
`timescale 1ns / 1ps
package lfim_pkg;

	localparam int FRAC_BITS         = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_N            = 24;
	localparam int CFRAC             = 30;
	localparam int RSH               = CFRAC - FRAC_BITS;

	localparam int QW  = 32;   // Q16.16 word
	localparam int THW = 19;   // theta field
	localparam int ZW  = 35;   // CORDIC angle accumulator
	localparam int XW  = 34;   // CORDIC x/y datapath
	localparam int SCW = 18;   // rounded sine/cosine

	localparam int DW      = QW + FRAC_BITS;  // dividend bits after scaling
	localparam int DIV_LAT = DW + 2;

	localparam logic signed [ZW-1:0] PI_C      = 35'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_C = 35'sd1686629713;
	localparam logic signed [ZW-1:0] TWO_PI_C  = 35'sd6746518852;
	localparam logic signed [XW-1:0] GAIN_C    = 34'sd652032874;

	localparam longint PI_F  = (64'sd3373259426 + (64'sd1 <<< (RSH - 1))) >>> RSH;
	localparam logic signed [20:0] PI_FW = 21'(PI_F);
	localparam logic signed [20:0] TP_FW = 21'(2 * PI_F);

	localparam logic signed [QW-1:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [QW-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [QW-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

	typedef enum logic [2:0] {
		REG_PLANE_A        = 3'd0,
		REG_PLANE_B        = 3'd1,
		REG_PLANE_C        = 3'd2,
		REG_PLANE_D        = 3'd3,
		REG_PLANE_D_MIN    = 3'd4,
		REG_FEATURE_SELECT = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		ROW_RHO   = 1'b0,
		ROW_THETA = 1'b1
	} row_kind_t;

	typedef struct packed {
		logic [1:0]           mask;
		logic signed [QW-1:0] rho_err;
		logic signed [QW-1:0] th_err;
	} side_t;

	typedef struct packed {
		side_t                 side;
		logic signed [SCW-1:0] co;
		logic signed [SCW-1:0] si;
		logic signed [QW-1:0]  rho;
	} carry_t;

	typedef struct packed {
		carry_t               c;
		logic signed [QW-1:0] m3r;
		logic signed [QW-1:0] m4r;
		logic signed [QW-1:0] m3t;
		logic signed [QW-1:0] m4t;
	} mid_t;

	typedef struct packed {
		logic signed [QW-1:0] vx;
		logic signed [QW-1:0] vy;
		logic signed [QW-1:0] vz;
		logic signed [QW-1:0] wx;
		logic signed [QW-1:0] wy;
		logic signed [QW-1:0] wz;
		logic signed [QW-1:0] err;
	} row_t;

	function automatic logic signed [QW-1:0] sat64(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return S_MAX;
		if (v < -64'sd2147483648) return S_MIN;
		return v[QW-1:0];
	endfunction

	function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [63:0] p;
		logic signed [63:0] r;
		p = 64'(a) * 64'(b);
		r = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return sat64(r);
	endfunction

	function automatic logic signed [QW-1:0] add_sat(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [QW:0] s;
		s = {a[QW-1], a} + {b[QW-1], b};
		if (s[QW] != s[QW-1]) return s[QW] ? S_MIN : S_MAX;
		return s[QW-1:0];
	endfunction

	function automatic logic signed [QW-1:0] sub_sat(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [QW:0] s;
		s = {a[QW-1], a} - {b[QW-1], b};
		if (s[QW] != s[QW-1]) return s[QW] ? S_MIN : S_MAX;
		return s[QW-1:0];
	endfunction

	function automatic logic signed [QW-1:0] neg_sat(input logic signed [QW-1:0] a);
		if (a == S_MIN) return S_MAX;
		return -a;
	endfunction

	function automatic logic signed [ZW-1:0] atan_c(input int i);
		case (i)
			0:       return 35'sd843314857;
			1:       return 35'sd497837829;
			2:       return 35'sd263043837;
			3:       return 35'sd133525159;
			4:       return 35'sd67021688;
			5:       return 35'sd33543516;
			6:       return 35'sd16775851;
			7:       return 35'sd8388437;
			8:       return 35'sd4194283;
			9:       return 35'sd2097149;
			10:      return 35'sd1048576;
			11:      return 35'sd524288;
			12:      return 35'sd262144;
			13:      return 35'sd131072;
			14:      return 35'sd65536;
			15:      return 35'sd32768;
			16:      return 35'sd16384;
			17:      return 35'sd8192;
			18:      return 35'sd4096;
			19:      return 35'sd2048;
			20:      return 35'sd1024;
			21:      return 35'sd512;
			22:      return 35'sd256;
			23:      return 35'sd128;
			default: return '0;
		endcase
	endfunction

endpackage

### hw/rtl/lfim_cordic.sv
// Pipelined CORDIC producing cosine and sine of the line angle.
`timescale 1ns / 1ps
module lfim_cordic #(
	parameter int STAGES = lfim_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [lfim_pkg::THW-1:0]     theta,
	output logic signed [lfim_pkg::SCW-1:0]     cos_o,
	output logic signed [lfim_pkg::SCW-1:0]     sin_o
);
	import lfim_pkg::*;

	localparam int NC = (STAGES > ATAN_N) ? ATAN_N : STAGES;

	logic signed [ZW-1:0] z_s [0:NC];
	logic signed [XW-1:0] x_s [0:NC];
	logic signed [XW-1:0] y_s [0:NC];
	logic                 flip_s [0:NC];

	logic signed [ZW-1:0] z_in;
	logic signed [ZW-1:0] z_wrap;
	logic signed [ZW-1:0] z_fold;
	logic                 fold;
	logic signed [XW-1:0] x_f;
	logic signed [XW-1:0] y_f;
	logic signed [XW-1:0] x_r;
	logic signed [XW-1:0] y_r;

	// bring angle into [-pi, pi], then fold into [-pi/2, pi/2]
	always_comb begin
		z_in = ZW'(theta) <<< RSH;
		if (z_in > PI_C) begin
			z_wrap = z_in - TWO_PI_C;
		end else if (z_in < -PI_C) begin
			z_wrap = z_in + TWO_PI_C;
		end else begin
			z_wrap = z_in;
		end
		fold = 1'b0;
		z_fold = z_wrap;
		if (z_wrap > HALF_PI_C) begin
			z_fold = z_wrap - PI_C;
			fold = 1'b1;
		end else if (z_wrap < -HALF_PI_C) begin
			z_fold = z_wrap + PI_C;
			fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0]    <= z_fold;
			x_s[0]    <= GAIN_C;
			y_s[0]    <= '0;
			flip_s[0] <= fold;
		end
	end

	for (genvar i = 0; i < NC; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_c(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_c(i);
				end
			end
		end
	end

	always_comb begin
		x_f = flip_s[NC] ? -x_s[NC] : x_s[NC];
		y_f = flip_s[NC] ? -y_s[NC] : y_s[NC];
		x_r = (x_f + (XW'(1) <<< (RSH - 1))) >>> RSH;
		y_r = (y_f + (XW'(1) <<< (RSH - 1))) >>> RSH;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o <= x_r[SCW-1:0];
			sin_o <= y_r[SCW-1:0];
		end
	end

endmodule

### hw/rtl/lfim_div.sv
// Pipelined restoring divider: (num << FRAC_BITS) / den, truncated and saturated.
`timescale 1ns / 1ps
module lfim_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [lfim_pkg::QW-1:0]  num,
	input  logic        [lfim_pkg::QW-1:0]  den_mag,
	input  logic                            den_neg,
	output logic signed [lfim_pkg::QW-1:0]  quo
);
	import lfim_pkg::*;

	logic [QW-1:0] rem_s [0:DW];
	logic [DW-1:0] dvd_s [0:DW];
	logic [DW-1:0] q_s   [0:DW];
	logic          neg_s [0:DW];

	logic [QW-1:0] num_mag;
	logic [DW-1:0] q_fin;

	assign num_mag = num[QW-1] ? QW'(-num) : QW'(num);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			dvd_s[0] <= {num_mag, {FRAC_BITS{1'b0}}};
			q_s[0]   <= '0;
			neg_s[0] <= num[QW-1] ^ den_neg;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < DW; k++) begin : g_bit
		logic [QW:0] trial;
		assign trial = {rem_s[k], dvd_s[k][DW-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[k+1] <= {dvd_s[k][DW-2:0], 1'b0};
				neg_s[k+1] <= neg_s[k];
				if (trial >= {1'b0, den_mag}) begin
					rem_s[k+1] <= QW'(trial - {1'b0, den_mag});
					q_s[k+1]   <= {q_s[k][DW-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= trial[QW-1:0];
					q_s[k+1]   <= {q_s[k][DW-2:0], 1'b0};
				end
			end
		end
	end

	assign q_fin = q_s[DW];

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[DW]) begin
				if (q_fin > DW'(64'd2147483648)) quo <= S_MIN;
				else quo <= -$signed(q_fin[QW-1:0]);
			end else begin
				if (q_fin > DW'(64'd2147483647)) quo <= S_MAX;
				else quo <= $signed(q_fin[QW-1:0]);
			end
		end
	end

endmodule

### hw/rtl/line_feature_interaction_matrix.sv
// Top level: interaction-matrix rows and errors for a 2D image line feature.
// Throughput: one input word per cycle while each produces at most one row and the
// receiver is ready; an input that selects both rows holds the last stage until
// both output words are sent.
// The 48-stage divider and the CORDIC set the depth; every stage advances together.
// Reset (arst_n low) clears all valid bits and loads the register reset values.
`timescale 1ns / 1ps
module line_feature_interaction_matrix #(
	parameter int CORDIC_STAGES = lfim_pkg::CORDIC_STAGES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write port
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata: line_rho[31:0], line_theta[50:32], desired_rho[82:51],
	//          desired_theta[101:83], zero fill [103:102]
	input  logic [103:0] s_tdata,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata: col_vx[31:0], col_vy[63:32], col_vz[95:64], col_wx[127:96],
	//          col_wy[159:128], col_wz[191:160], feature_error[223:192],
	//          plane_invalid[224], zero fill [231:225]
	output logic [231:0] m_tdata,
	// m_tuser: row_kind[0]
	output logic [0:0]   m_tuser,
	output logic         m_tlast
);
	import lfim_pkg::*;

	localparam int LC = ((CORDIC_STAGES > ATAN_N) ? ATAN_N : CORDIC_STAGES) + 2;

	// configuration registers
	logic signed [QW-1:0] plane_a_q, plane_b_q, plane_c_q, plane_d_q;
	logic [15:0]          plane_d_min_q;
	logic [1:0]           feature_select_q;
	logic                 inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_a_q        <= '0;
			plane_b_q        <= '0;
			plane_c_q        <= '0;
			plane_d_q        <= '0;
			plane_d_min_q    <= 16'd1;
			feature_select_q <= 2'd3;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_PLANE_A:        plane_a_q        <= cfg_data;
				REG_PLANE_B:        plane_b_q        <= cfg_data;
				REG_PLANE_C:        plane_c_q        <= cfg_data;
				REG_PLANE_D:        plane_d_q        <= cfg_data;
				REG_PLANE_D_MIN:    plane_d_min_q    <= cfg_data[15:0];
				REG_FEATURE_SELECT: feature_select_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// |D| and the plane check; the user must change D only while the pipe is empty, the block has no guard for it
	logic [QW:0]   d_abs;
	logic [QW-1:0] d_mag;
	assign d_abs = plane_d_q[QW-1] ? -{plane_d_q[QW-1], plane_d_q} : {1'b0, plane_d_q};
	assign d_mag = d_abs[QW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 1'b1;
		end else begin
			inv_q <= (plane_d_q == '0) || (d_abs < {17'd0, plane_d_min_q});
		end
	end

	// global advance: the whole pipe moves unless the output stage owes a row that is not being sent this cycle
	logic       adv;
	logic       v_s7;
	logic [1:0] pend_s7;
	logic       out_fire;
	logic       pend_one;

	assign pend_one = (pend_s7 == 2'b01) || (pend_s7 == 2'b10);
	assign out_fire = m_tvalid && m_tready;
	assign adv      = !v_s7 || (pend_s7 == 2'b00) || (out_fire && pend_one);
	assign s_tready = adv;

	// stage 1: capture the word, form both errors
	logic signed [QW-1:0]  rho_in, drho_in;
	logic signed [THW-1:0] th_in, dth_in;
	logic signed [20:0]    te_raw, te_wrap;

	assign rho_in  = s_tdata[31:0];
	assign th_in   = s_tdata[50:32];
	assign drho_in = s_tdata[82:51];
	assign dth_in  = s_tdata[101:83];

	// difference spans less than two turns, so one correction wraps it
	always_comb begin
		te_raw = 21'(th_in) - 21'(dth_in);
		if (te_raw < -PI_FW) begin
			te_wrap = te_raw + TP_FW;
		end else if (te_raw > PI_FW) begin
			te_wrap = te_raw - TP_FW;
		end else begin
			te_wrap = te_raw;
		end
	end

	logic                  v_s1;
	side_t                 side_s1;
	logic signed [QW-1:0]  rho_s1;
	logic signed [THW-1:0] th_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.mask    <= feature_select_q;
			side_s1.rho_err <= sub_sat(rho_in, drho_in);
			side_s1.th_err  <= QW'(te_wrap);
			rho_s1          <= rho_in;
			th_s1           <= th_in;
		end
	end

	// CORDIC; sideband rides a matching delay line
	logic signed [SCW-1:0] co_c, si_c;

	lfim_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk   (clk),
		.en    (adv),
		.theta (th_s1),
		.cos_o (co_c),
		.sin_o (si_c)
	);

	logic                 vc_q   [0:LC-1];
	side_t                sidec_q[0:LC-1];
	logic signed [QW-1:0] rhoc_q [0:LC-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LC; k++) vc_q[k] <= 1'b0;
		end else if (adv) begin
			vc_q[0] <= v_s1;
			for (int k = 1; k < LC; k++) vc_q[k] <= vc_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sidec_q[0] <= side_s1;
			rhoc_q[0]  <= rho_s1;
			for (int k = 1; k < LC; k++) begin
				sidec_q[k] <= sidec_q[k-1];
				rhoc_q[k]  <= rhoc_q[k-1];
			end
		end
	end

	// stage 2: first products
	logic                 v_s2;
	carry_t               c_s2;
	logic signed [QW-1:0] pa_si_s2, pb_co_s2, ra_s2, rb_s2, rr0_s2;

	// stage 3: theta coupling numerator, rho products with the angle
	logic                 v_s3;
	carry_t               c_s3;
	logic signed [QW-1:0] ltn_s3, t1_s3, t2_s3, rr_s3;

	// stage 4: partial rho coupling numerator, row entries that need no division
	logic                 v_s4;
	carry_t               c_s4;
	logic signed [QW-1:0] ltn_s4, t2_s4, lra_s4;
	logic signed [QW-1:0] m3r_s4, m4r_s4, m3t_s4, m4t_s4;

	// stage 5: full rho coupling numerator, feed the dividers
	logic                 v_s5;
	mid_t                 mid_s5;
	logic signed [QW-1:0] ltn_s5, lrn_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s2 <= vc_q[LC-1];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s2.side <= sidec_q[LC-1];
			c_s2.rho  <= rhoc_q[LC-1];
			c_s2.co   <= co_c;
			c_s2.si   <= si_c;
			pa_si_s2  <= mulq(plane_a_q, QW'(si_c));
			pb_co_s2  <= mulq(plane_b_q, QW'(co_c));
			ra_s2     <= mulq(rhoc_q[LC-1], plane_a_q);
			rb_s2     <= mulq(rhoc_q[LC-1], plane_b_q);
			rr0_s2    <= mulq(rhoc_q[LC-1], rhoc_q[LC-1]);

			c_s3   <= c_s2;
			ltn_s3 <= sub_sat(pa_si_s2, pb_co_s2);
			t1_s3  <= mulq(ra_s2, QW'(c_s2.co));
			t2_s3  <= mulq(rb_s2, QW'(c_s2.si));
			rr_s3  <= add_sat(ONE_Q, rr0_s2);

			c_s4   <= c_s3;
			ltn_s4 <= ltn_s3;
			t2_s4  <= t2_s3;
			lra_s4 <= add_sat(plane_c_q, t1_s3);
			m3r_s4 <= mulq(QW'(c_s3.si), rr_s3);
			m4r_s4 <= neg_sat(mulq(QW'(c_s3.co), rr_s3));
			m3t_s4 <= neg_sat(mulq(c_s3.rho, QW'(c_s3.co)));
			m4t_s4 <= neg_sat(mulq(c_s3.rho, QW'(c_s3.si)));

			mid_s5.c   <= c_s4;
			mid_s5.m3r <= m3r_s4;
			mid_s5.m4r <= m4r_s4;
			mid_s5.m3t <= m3t_s4;
			mid_s5.m4t <= m4t_s4;
			ltn_s5     <= ltn_s4;
			lrn_s5     <= add_sat(lra_s4, t2_s4);
		end
	end

	// divide both numerators by D
	logic signed [QW-1:0] lr_d, lt_d;

	lfim_div u_div_rho (
		.clk     (clk),
		.en      (adv),
		.num     (lrn_s5),
		.den_mag (d_mag),
		.den_neg (plane_d_q[QW-1]),
		.quo     (lr_d)
	);

	lfim_div u_div_theta (
		.clk     (clk),
		.en      (adv),
		.num     (ltn_s5),
		.den_mag (d_mag),
		.den_neg (plane_d_q[QW-1]),
		.quo     (lt_d)
	);

	logic vd_q  [0:DIV_LAT-1];
	mid_t midd_q[0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) vd_q[k] <= 1'b0;
		end else if (adv) begin
			vd_q[0] <= v_s5;
			for (int k = 1; k < DIV_LAT; k++) vd_q[k] <= vd_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			midd_q[0] <= mid_s5;
			for (int k = 1; k < DIV_LAT; k++) midd_q[k] <= midd_q[k-1];
		end
	end

	// stage 6: coupling products, assemble both rows
	mid_t md;
	assign md = midd_q[DIV_LAT-1];

	logic       v_s6;
	logic [1:0] mask_s6;
	row_t       rrow_s6, trow_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= vd_q[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mask_s6     <= md.c.side.mask;
			rrow_s6.vx  <= mulq(QW'(md.c.co), lr_d);
			rrow_s6.vy  <= mulq(QW'(md.c.si), lr_d);
			rrow_s6.vz  <= neg_sat(mulq(md.c.rho, lr_d));
			rrow_s6.wx  <= md.m3r;
			rrow_s6.wy  <= md.m4r;
			rrow_s6.wz  <= '0;
			rrow_s6.err <= md.c.side.rho_err;
			trow_s6.vx  <= mulq(QW'(md.c.co), lt_d);
			trow_s6.vy  <= mulq(QW'(md.c.si), lt_d);
			trow_s6.vz  <= neg_sat(mulq(md.c.rho, lt_d));
			trow_s6.wx  <= md.m3t;
			trow_s6.wy  <= md.m4t;
			trow_s6.wz  <= -ONE_Q;
			trow_s6.err <= md.c.side.th_err;
		end
	end

	// stage 7: output register; pend_s7 lists rows still owed, rho first
	row_t rrow_s7, trow_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7    <= 1'b0;
			pend_s7 <= 2'b00;
		end else if (adv) begin
			v_s7    <= v_s6;
			pend_s7 <= v_s6 ? mask_s6 : 2'b00;
		end else if (out_fire) begin
			// drop the row just sent
			pend_s7 <= pend_s7[0] ? {pend_s7[1], 1'b0} : 2'b00;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rrow_s7 <= rrow_s6;
			trow_s7 <= trow_s6;
		end
	end

	row_t      cur;
	row_kind_t kind;

	always_comb begin
		kind = pend_s7[0] ? ROW_RHO : ROW_THETA;
		cur  = pend_s7[0] ? rrow_s7 : trow_s7;
		if (inv_q) begin
			cur.vx = '0;
			cur.vy = '0;
			cur.vz = '0;
			cur.wx = '0;
			cur.wy = '0;
			cur.wz = '0;
		end
	end

	assign m_tvalid = v_s7 && (pend_s7 != 2'b00);
	assign m_tlast  = pend_one;
	assign m_tuser  = kind;
	assign m_tdata  = {7'd0, inv_q, cur.err, cur.wz, cur.wy, cur.wx, cur.vz, cur.vy, cur.vx};

	// a rho row that is not the last is followed at once by the theta row
	a_theta_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !m_tlast |=> m_tvalid && (m_tuser == ROW_THETA))
		else $error("theta row did not follow rho row");

	// input is held off while two rows are still owed
	a_hold_two: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && (pend_s7 == 2'b11) |-> !s_tready)
		else $error("input taken while output stage owes two rows");

	// an invalid plane shows zero matrix entries
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[224] |-> (m_tdata[191:0] == '0))
		else $error("nonzero entries on an invalid plane");

	// rho rows have no wz term
	a_rho_wz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ROW_RHO) |-> (m_tdata[191:160] == '0))
		else $error("rho row carries a wz entry");

endmodule

### bench/lfim_row_checker.sv
// Row checker: predicts interaction-matrix rows from accepted words and compares results.
`timescale 1ns / 1ps
module lfim_row_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [231:0] m_tdata,
	input  logic [0:0]   m_tuser,
	input  logic         m_tlast,
	output int           errors,
	output int           pending,
	output int           rows_seen,
	output int           invalid_rows
);
	import lfim_pkg::*;

	typedef struct {
		row_kind_t kind;
		longint    col [6];
		longint    ferr;
		bit        inv;
		bit        last;
	} matrix_row_t;

	localparam longint TURN   = 64'sd6746518852;
	localparam longint HALF_T = 64'sd3373259426;
	localparam longint QUART  = 64'sd1686629713;
	localparam longint K_GAIN = 64'sd652032874;
	localparam longint ONE    = 64'sd65536;
	localparam longint ARCTAN [0:15] = '{
		843314857, 497837829, 263043837, 133525159, 67021688, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
		131072, 65536, 32768};

	matrix_row_t rows_due[$];
	longint pa, pb, pc, pd, dmin;
	bit [1:0] sel;

	function automatic longint clip(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return clip((a * b + 64'sd32768) >>> 16);
	endfunction

	function automatic longint qdiv(input longint num, input longint den);
		return clip((num * ONE) / den);
	endfunction

	function automatic longint to_q16(input longint v);
		return (v + 64'sd8192) >>> 14;
	endfunction

	// CORDIC rotation with quadrant fold, same angle scaling as the block
	task automatic trig(input longint th, output longint co, output longint si);
		longint z, x, y, nx;
		bit flip;
		z = (th * 64'sd16384) % TURN;
		x = K_GAIN;
		y = 0;
		flip = 0;
		if (z > HALF_T) z -= TURN;
		if (z < -HALF_T) z += TURN;
		if (z > QUART) begin
			z -= HALF_T;
			flip = 1;
		end else if (z < -QUART) begin
			z += HALF_T;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ARCTAN[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		co = to_q16(x);
		si = to_q16(y);
	endtask

	task automatic predict_rows(input logic [103:0] w);
		longint rho, th, drho, dth, co, si, lr, lt, rr, pif, tp, e;
		bit inv;
		int n0;
		matrix_row_t r;
		rho  = longint'(signed'(w[31:0]));
		th   = longint'(signed'(w[50:32]));
		drho = longint'(signed'(w[82:51]));
		dth  = longint'(signed'(w[101:83]));
		lr = 0;
		lt = 0;
		n0 = rows_due.size();
		trig(th, co, si);
		inv = (pd == 0) || ((pd < 0 ? -pd : pd) < dmin);
		if (!inv) begin
			lt = qdiv(clip(qmul(pa, si) - qmul(pb, co)), pd);
			lr = clip(pc + qmul(qmul(rho, pa), co));
			lr = qdiv(clip(lr + qmul(qmul(rho, pb), si)), pd);
		end
		if (sel[0]) begin
			rr = clip(ONE + qmul(rho, rho));
			r.kind = ROW_RHO;
			r.col[0] = qmul(co, lr);
			r.col[1] = qmul(si, lr);
			r.col[2] = clip(-qmul(rho, lr));
			r.col[3] = qmul(si, rr);
			r.col[4] = clip(-qmul(co, rr));
			r.col[5] = 0;
			r.ferr = clip(rho - drho);
			r.inv = inv;
			r.last = 0;
			rows_due.push_back(r);
		end
		if (sel[1]) begin
			// wrap by whole turns of the rounded 2*pi
			pif = to_q16(HALF_T);
			tp = 2 * pif;
			e = th - dth;
			if (e < -pif) e += ((-pif - e + tp - 1) / tp) * tp;
			if (e > pif) e -= ((e - pif + tp - 1) / tp) * tp;
			r.kind = ROW_THETA;
			r.col[0] = qmul(co, lt);
			r.col[1] = qmul(si, lt);
			r.col[2] = clip(-qmul(rho, lt));
			r.col[3] = clip(-qmul(rho, co));
			r.col[4] = clip(-qmul(rho, si));
			r.col[5] = -ONE;
			r.ferr = clip(e);
			r.inv = inv;
			r.last = 0;
			rows_due.push_back(r);
		end
		if (rows_due.size() > n0) rows_due[$].last = 1;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic check_row();
		matrix_row_t r;
		logic inv;
		inv = m_tdata[224];
		rows_seen++;
		if (inv) invalid_rows++;
		if (rows_due.size() == 0) begin
			$error("row_kind: expected no row, got %0d", m_tuser[0]);
			errors++;
			return;
		end
		r = rows_due.pop_front();
		check_field("row_kind", r.kind, m_tuser[0]);
		check_field("col_vx", r.inv ? 0 : r.col[0], signed'(m_tdata[31:0]));
		check_field("col_vy", r.inv ? 0 : r.col[1], signed'(m_tdata[63:32]));
		check_field("col_vz", r.inv ? 0 : r.col[2], signed'(m_tdata[95:64]));
		check_field("col_wx", r.inv ? 0 : r.col[3], signed'(m_tdata[127:96]));
		check_field("col_wy", r.inv ? 0 : r.col[4], signed'(m_tdata[159:128]));
		check_field("col_wz", r.inv ? 0 : r.col[5], signed'(m_tdata[191:160]));
		check_field("feature_error", r.ferr, signed'(m_tdata[223:192]));
		check_field("plane_invalid", r.inv, inv);
		check_field("last_row", r.last, m_tlast);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa = 0;
			pb = 0;
			pc = 0;
			pd = 0;
			dmin = 1;
			sel = 2'd3;
			errors = 0;
			rows_seen = 0;
			invalid_rows = 0;
			rows_due.delete();
		end else begin
			if (m_tvalid && m_tready) check_row();
			if (s_tvalid && s_tready) predict_rows(s_tdata);
			if (cfg_we) begin
				case (cfg_index)
					REG_PLANE_A:        pa = longint'(signed'(cfg_data));
					REG_PLANE_B:        pb = longint'(signed'(cfg_data));
					REG_PLANE_C:        pc = longint'(signed'(cfg_data));
					REG_PLANE_D:        pd = longint'(signed'(cfg_data));
					REG_PLANE_D_MIN:    dmin = cfg_data[15:0];
					REG_FEATURE_SELECT: sel = cfg_data[1:0];
					default: ;
				endcase
			end
		end
		pending = rows_due.size();
	end

endmodule

### bench/tb_line_feature_interaction_matrix.sv
// Testbench top: clock, reset, configuration phases, line stimulus and verdict.
`timescale 1ns / 1ps
module tb_line_feature_interaction_matrix;
	import lfim_pkg::*;

	// an index past the register list; the block must ignore it
	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam int LIMIT = 400000;
	localparam int SETTLE = 120;  // comfortably past the full pipeline depth

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_we = 0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [231:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         m_tlast;

	int errors, pending, rows_seen, invalid_rows;
	int cycles = 0;
	int words_sent = 0;
	bit quiet = 0;      // no idling on either side
	bit hold_req = 0;   // ask the receiver for one long hold-off

	always #2 clk = ~clk;

	line_feature_interaction_matrix u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	lfim_row_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.errors(errors), .pending(pending), .rows_seen(rows_seen),
		.invalid_rows(invalid_rows)
	);

	// Watchdog: stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("line_feature_interaction_matrix verification failed");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold-off on request, none when quiet
	initial begin
		int stall;
		int hold_left;
		stall = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 0;
			end else if (quiet) begin
				m_tready <= 1;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall = $urandom_range(0, 7);
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	// Write one register; hold the enable high across back-to-back writes
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic setup_plane(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d, input logic [15:0] dm,
			input logic [1:0] sel);
		write_reg(REG_PLANE_A, a);
		write_reg(REG_PLANE_B, b);
		write_reg(REG_PLANE_C, c);
		write_reg(REG_PLANE_D, d);
		write_reg(REG_PLANE_D_MIN, {16'd0, dm});
		write_reg(REG_FEATURE_SELECT, {30'd0, sel});
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// Offer one line word, with an occasional sender gap first
	task automatic send_line(input logic [31:0] rho, input logic [18:0] th,
			input logic [31:0] drho, input logic [18:0] dth);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			s_tvalid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1;
		s_tdata <= {2'b00, dth, drho, th, rho};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	function automatic logic [31:0] pick_q();
		// mostly modest magnitudes, sometimes the full range
		if ($urandom_range(0, 2) == 0) return $urandom;
		return 32'(signed'(19'($urandom)));
	endfunction

	task automatic random_lines(input int n);
		repeat (n) send_line(pick_q(), 19'($urandom), pick_q(), 19'($urandom));
	endtask

	// Drop valid, wait out every expected row, then let the pipeline drain
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic directed_lines();
		send_line(32'h0, 19'h0, 32'h0, 19'h0);
		send_line(32'h7FFF_FFFF, 19'h3FFFF, 32'h8000_0000, 19'h40000);
		send_line(32'h8000_0000, 19'h40000, 32'h7FFF_FFFF, 19'h3FFFF);
		send_line(32'h0001_0000, 19'd102944, 32'h0, 19'h0);              // near pi/2
		send_line(32'hFFFF_0000, 19'(-205887), 32'h0, 19'd205887);       // -pi, wrap up
		send_line(32'h0002_0000, 19'd205888, 32'h0, 19'(-205888));       // past pi, wrap down
		send_line(32'hFFFF_FFFF, 19'h7FFFF, 32'h0000_0001, 19'h00001);
		send_line(32'h0100_0000, 19'd51472, 32'hFF00_0000, 19'd154416);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Reset values: D is zero, so every row comes out flagged invalid
		directed_lines();
		random_lines(60);
		settle();

		// Ordinary plane, both rows
		setup_plane(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h0001_0000,
			16'd1, 2'd3);
		directed_lines();
		random_lines(280);
		settle();

		// Negative D above the largest threshold, rho row only
		setup_plane(32'hFFFE_0000, 32'h0003_0000, 32'h0000_4000, 32'hFFFD_0000,
			16'hFFFF, 2'd1);
		random_lines(200);
		settle();

		// Tiny D under the threshold, theta row only
		setup_plane(32'h0005_0000, 32'hFFFF_8000, 32'h0001_0000, 32'h0000_0064,
			16'hFFFF, 2'd2);
		random_lines(200);
		settle();

		// Extreme coefficients, zero threshold, long output hold-off
		setup_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
			16'd0, 2'd3);
		directed_lines();
		hold_req = 1;
		random_lines(280);
		settle();

		// Empty select yields nothing; a spare index must change nothing
		setup_plane(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			16'd1, 2'd0);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		@(negedge clk);
		cfg_we <= 0;
		random_lines(40);
		settle();
		setup_plane(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF,
			16'd1, 2'd3);
		random_lines(40);
		settle();

		// Random planes
		repeat (4) begin
			setup_plane(pick_q(), pick_q(), pick_q(), $urandom_range(0, 1) ?
				pick_q() : $urandom, 16'($urandom_range(0, 65535)),
				2'($urandom_range(1, 3)));
			random_lines(150);
			settle();
		end

		// Last stretch runs flat out
		quiet = 1;
		setup_plane(32'h0000_C000, 32'hFFFF_4000, 32'h0003_0000, 32'h0002_0000,
			16'd1, 2'd3);
		random_lines(300);
		settle();

		$display("Sent %0d line words in 12 plane settings; %0d rows checked, %0d invalid.",
			words_sent, rows_seen, invalid_rows);
		if (errors == 0) begin
			$display("line_feature_interaction_matrix verification clean");
		end else begin
			$display("line_feature_interaction_matrix verification failed");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/lfim_pkg.sv
hw/rtl/lfim_cordic.sv
hw/rtl/lfim_div.sv
hw/rtl/line_feature_interaction_matrix.sv
bench/lfim_row_checker.sv
bench/tb_line_feature_interaction_matrix.sv
